// ----- rtl/dbd_pkg.sv -----
`timescale 1ns / 1ps

package dbd_pkg;

  // Default number of bins per box side.
  localparam int BINS_DEF = 16;

  // Width of the bin tag carried with each item; covers the largest bin count.
  localparam int IDX_W = 5;

  // Item codes.
  localparam logic CMD_BOX = 1'b0;
  localparam logic CMD_CLS = 1'b1;

  // One classified item as it travels from the front to the back.
  typedef struct packed {
    logic               cmd;
    logic signed [15:0] logit;
    logic [7:0]         grid_x;
    logic [7:0]         grid_y;
    logic [1:0]         stride_code;
    logic [IDX_W-1:0]   bin;
    logic [1:0]         side;
    logic               last_bin;
    logic               last_side;
  } dbd_item_t;

  // exp(-i) for integer part i, Q0.16. Integer parts above eleven give zero.
  function automatic logic [16:0] exp_int(input logic [3:0] ip);
    logic [16:0] r;
    case (ip)
      4'd0:    r = 17'd65536;
      4'd1:    r = 17'd24109;
      4'd2:    r = 17'd8869;
      4'd3:    r = 17'd3263;
      4'd4:    r = 17'd1200;
      4'd5:    r = 17'd442;
      4'd6:    r = 17'd162;
      4'd7:    r = 17'd60;
      4'd8:    r = 17'd22;
      4'd9:    r = 17'd8;
      4'd10:   r = 17'd3;
      4'd11:   r = 17'd1;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

  // exp(-h/16), Q0.16.
  function automatic logic [16:0] exp_hi(input logic [3:0] h);
    logic [16:0] r;
    case (h)
      4'd0:    r = 17'd65536;
      4'd1:    r = 17'd61565;
      4'd2:    r = 17'd57835;
      4'd3:    r = 17'd54331;
      4'd4:    r = 17'd51039;
      4'd5:    r = 17'd47947;
      4'd6:    r = 17'd45042;
      4'd7:    r = 17'd42313;
      4'd8:    r = 17'd39750;
      4'd9:    r = 17'd37341;
      4'd10:   r = 17'd35079;
      4'd11:   r = 17'd32954;
      4'd12:   r = 17'd30957;
      4'd13:   r = 17'd29081;
      4'd14:   r = 17'd27319;
      default: r = 17'd25664;
    endcase
    return r;
  endfunction

  // exp(-l/256), Q0.16.
  function automatic logic [16:0] exp_lo(input logic [3:0] l);
    logic [16:0] r;
    case (l)
      4'd0:    r = 17'd65536;
      4'd1:    r = 17'd65280;
      4'd2:    r = 17'd65026;
      4'd3:    r = 17'd64772;
      4'd4:    r = 17'd64520;
      4'd5:    r = 17'd64268;
      4'd6:    r = 17'd64018;
      4'd7:    r = 17'd63768;
      4'd8:    r = 17'd63520;
      4'd9:    r = 17'd63272;
      4'd10:   r = 17'd63025;
      4'd11:   r = 17'd62780;
      4'd12:   r = 17'd62535;
      4'd13:   r = 17'd62291;
      4'd14:   r = 17'd62048;
      default: r = 17'd61806;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/dbd_front.sv -----
`timescale 1ns / 1ps

module dbd_front #(
  parameter int BINS = dbd_pkg::BINS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  logic               q_full_i,
  input  logic               command_i,
  input  logic signed [15:0] logit_i,
  input  logic [7:0]         grid_x_i,
  input  logic [7:0]         grid_y_i,
  input  logic [1:0]         stride_code_i,
  output logic               q_push_o,
  output dbd_pkg::dbd_item_t q_item_o
);

  localparam int BW = (BINS > 1) ? $clog2(BINS) : 1;

  logic [BW-1:0] bin_cnt_q, bin_cnt_d;
  logic [1:0]    side_cnt_q, side_cnt_d;
  logic          accept;
  logic          last_bin;
  logic          last_side;

  assign accept    = push_i && !q_full_i;
  assign last_bin  = (bin_cnt_q == BW'(BINS - 1));
  assign last_side = (side_cnt_q == 2'd3);

  // Tag each beat with its bin and side position.
  always_comb begin
    q_item_o             = '0;
    q_item_o.cmd         = command_i;
    q_item_o.logit       = logit_i;
    q_item_o.grid_x      = grid_x_i;
    q_item_o.grid_y      = grid_y_i;
    q_item_o.stride_code = stride_code_i;
    q_item_o.bin         = dbd_pkg::IDX_W'(bin_cnt_q);
    q_item_o.side        = side_cnt_q;
    q_item_o.last_bin    = last_bin;
    q_item_o.last_side   = last_side;
  end

  assign q_push_o = accept;

  // Box beats advance the bin and side counters; class beats leave them alone.
  always_comb begin
    bin_cnt_d  = bin_cnt_q;
    side_cnt_d = side_cnt_q;
    if (accept && command_i == dbd_pkg::CMD_BOX) begin
      if (last_bin) begin
        bin_cnt_d  = '0;
        side_cnt_d = side_cnt_q + 2'd1;
      end else begin
        bin_cnt_d = bin_cnt_q + BW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_cnt_q  <= '0;
      side_cnt_q <= '0;
    end else begin
      bin_cnt_q  <= bin_cnt_d;
      side_cnt_q <= side_cnt_d;
    end
  end

endmodule

// ----- rtl/dbd_fifo.sv -----
`timescale 1ns / 1ps

module dbd_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  dbd_pkg::dbd_item_t item_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output dbd_pkg::dbd_item_t item_o
);

  dbd_pkg::dbd_item_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Occupancy follows pushes and pops.
  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ----- rtl/dbd_back.sv -----
`timescale 1ns / 1ps

module dbd_back #(
  parameter int BINS = dbd_pkg::BINS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  dbd_pkg::dbd_item_t q_item_i,
  output logic               q_pop_o,
  output logic               empty_o,
  input  logic               pop_i,
  output logic               kind_o,
  output logic signed [15:0] left_x_o,
  output logic signed [15:0] top_y_o,
  output logic signed [15:0] right_x_o,
  output logic signed [15:0] bottom_y_o,
  output logic [15:0]        score_o
);

  localparam int BW   = (BINS > 1) ? $clog2(BINS) : 1;
  localparam int SUMW = 17 + BW;
  localparam int WSW  = 17 + 2 * BW;
  localparam int BNW  = WSW + 9;
  localparam int QW   = (BW + 8 > 17) ? BW + 8 : 17;
  localparam int DNW  = (BNW > 34) ? BNW : 34;
  localparam int RW   = DNW + QW;
  localparam int DENW = (SUMW > 18) ? SUMW : 18;
  localparam int IW   = $clog2(QW);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MAX  = 4'd1;
  localparam logic [3:0] S_N    = 4'd2;
  localparam logic [3:0] S_E1   = 4'd3;
  localparam logic [3:0] S_E2   = 4'd4;
  localparam logic [3:0] S_ACC  = 4'd5;
  localparam logic [3:0] S_DSET = 4'd6;
  localparam logic [3:0] S_DIV  = 4'd7;
  localparam logic [3:0] S_DFIN = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  // Corner in Q8.8 grid units to saturated Q12.4 pixels.
  function automatic logic [15:0] to_pix(input logic signed [18:0] v,
                                         input logic [1:0] sc);
    logic signed [24:0] p;
    logic signed [20:0] q;
    logic [15:0]        r;
    case (sc)
      2'd0:    p = 25'(v) <<< 3;
      2'd1:    p = 25'(v) <<< 4;
      default: p = 25'(v) <<< 5;
    endcase
    p = p + 25'sd8;
    q = 21'(p >>> 4);
    if (q > 21'sd32767) begin
      r = 16'h7fff;
    end else if (q < -21'sd32768) begin
      r = 16'h8000;
    end else begin
      r = q[15:0];
    end
    return r;
  endfunction

  // Integer-part lookup with the out-of-range case folded in.
  function automatic logic [16:0] exp_int_sel(input logic [15:0] n);
    logic [16:0] r;
    if (n[15:8] > 8'd11) begin
      r = '0;
    end else begin
      r = dbd_pkg::exp_int(n[11:8]);
    end
    return r;
  endfunction

  logic [3:0]          state_q, state_d;
  logic signed [15:0]  bin_q [BINS];
  logic signed [15:0]  mx_q, mx_d;
  logic [BW-1:0]       k_q, k_d;
  logic [15:0]         n_q, n_d;
  logic [16:0]         p1_q, p1_d;
  logic [16:0]         e_q, e_d;
  logic [SUMW-1:0]     sum_q, sum_d;
  logic [WSW-1:0]      wsum_q, wsum_d;
  logic [RW-1:0]       rem_q, rem_d;
  logic [DENW-1:0]     den_q, den_d;
  logic [QW-1:0]       quot_q, quot_d;
  logic [IW-1:0]       i_q, i_d;
  logic                cls_q, cls_d;
  logic                neg_q, neg_d;
  logic [1:0]          side_q, side_d;
  logic                lside_q, lside_d;
  logic [7:0]          gx_q, gx_d, gy_q, gy_d;
  logic [1:0]          sc_q, sc_d;
  logic [11:0]         sd_q [4];
  logic                sd_we;
  logic [11:0]         sd_wdata;
  logic                bin_we;
  logic                ov_q, ov_d;
  logic                out_load;
  logic                out_kind;
  logic [15:0]         out_lx, out_ty, out_rx, out_by, out_score;
  logic [15:0]         score_q, score_d;
  logic [32:0]         prod1, prod2;
  logic [RW-1:0]       trial;
  logic [DENW-1:0]     cls_den;
  logic signed [16:0]  diff;
  logic signed [18:0]  cx, cy;

  assign diff  = 17'(mx_q) - 17'(bin_q[k_q]);
  assign prod1 = 33'(exp_int_sel(n_q)) * 33'(dbd_pkg::exp_hi(n_q[7:4]));
  assign prod2 = 33'(p1_q) * 33'(dbd_pkg::exp_lo(n_q[3:0]));
  assign trial = RW'(den_q) << i_q;
  assign cls_den = DENW'(18'd65536 + 18'(e_q));
  assign cx = 19'({1'b0, gx_q, 8'h80});
  assign cy = 19'({1'b0, gy_q, 8'h80});

  // Sequencer for bin capture, softmax expectation, sigmoid and output.
  always_comb begin
    state_d  = state_q;
    mx_d     = mx_q;
    k_d      = k_q;
    n_d      = n_q;
    p1_d     = p1_q;
    e_d      = e_q;
    sum_d    = sum_q;
    wsum_d   = wsum_q;
    rem_d    = rem_q;
    den_d    = den_q;
    quot_d   = quot_q;
    i_d      = i_q;
    cls_d    = cls_q;
    neg_d    = neg_q;
    side_d   = side_q;
    lside_d  = lside_q;
    gx_d     = gx_q;
    gy_d     = gy_q;
    sc_d     = sc_q;
    score_d  = score_q;
    sd_we    = 1'b0;
    sd_wdata = (quot_q > QW'(4095)) ? 12'd4095 : quot_q[11:0];
    bin_we   = 1'b0;
    q_pop_o  = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          if (q_item_i.cmd == dbd_pkg::CMD_CLS) begin
            cls_d   = 1'b1;
            neg_d   = q_item_i.logit[15];
            n_d     = q_item_i.logit[15] ? 16'(-q_item_i.logit) : q_item_i.logit;
            state_d = S_E1;
          end else begin
            bin_we = 1'b1;
            if (q_item_i.last_bin) begin
              cls_d   = 1'b0;
              side_d  = q_item_i.side;
              lside_d = q_item_i.last_side;
              gx_d    = q_item_i.grid_x;
              gy_d    = q_item_i.grid_y;
              sc_d    = q_item_i.stride_code;
              k_d     = '0;
              state_d = S_MAX;
            end
          end
        end
      end
      S_MAX: begin
        if (k_q == '0 || bin_q[k_q] > mx_q) begin
          mx_d = bin_q[k_q];
        end
        if (k_q == BW'(BINS - 1)) begin
          k_d     = '0;
          sum_d   = '0;
          wsum_d  = '0;
          state_d = S_N;
        end else begin
          k_d = k_q + BW'(1);
        end
      end
      S_N: begin
        n_d     = diff[15:0];
        state_d = S_E1;
      end
      S_E1: begin
        p1_d    = 17'((prod1 + 33'd32768) >> 16);
        state_d = S_E2;
      end
      S_E2: begin
        e_d     = 17'((prod2 + 33'd32768) >> 16);
        state_d = cls_q ? S_DSET : S_ACC;
      end
      S_ACC: begin
        sum_d  = sum_q + SUMW'(e_q);
        wsum_d = wsum_q + WSW'(e_q) * WSW'(k_q);
        if (k_q == BW'(BINS - 1)) begin
          state_d = S_DSET;
        end else begin
          k_d     = k_q + BW'(1);
          state_d = S_N;
        end
      end
      S_DSET: begin
        if (cls_q) begin
          den_d = cls_den;
          if (neg_q) begin
            rem_d = (RW'(e_q) << 16) + RW'(cls_den >> 1);
          end else begin
            rem_d = (RW'(1) << 32) + RW'(cls_den >> 1);
          end
        end else begin
          den_d = DENW'(sum_q);
          rem_d = (RW'(wsum_q) << 8) + RW'(sum_q >> 1);
        end
        quot_d  = '0;
        i_d     = IW'(QW - 1);
        state_d = S_DIV;
      end
      S_DIV: begin
        if (rem_q >= trial) begin
          rem_d  = rem_q - trial;
          quot_d = quot_q | (QW'(1) << i_q);
        end
        if (i_q == '0) begin
          state_d = S_DFIN;
        end else begin
          i_d = i_q - IW'(1);
        end
      end
      S_DFIN: begin
        if (cls_q) begin
          score_d = (quot_q > QW'(65535)) ? 16'hffff : quot_q[15:0];
          state_d = S_OUT;
        end else begin
          sd_we   = 1'b1;
          state_d = lside_q ? S_OUT : S_IDLE;
        end
      end
      S_OUT: begin
        if (!ov_q) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Result beat contents.
  always_comb begin
    out_kind  = cls_q;
    out_score = cls_q ? score_q : 16'd0;
    if (cls_q) begin
      out_lx = '0;
      out_ty = '0;
      out_rx = '0;
      out_by = '0;
    end else begin
      out_lx = to_pix(cx - 19'(sd_q[0]), sc_q);
      out_ty = to_pix(cy - 19'(sd_q[1]), sc_q);
      out_rx = to_pix(cx + 19'(sd_q[2]), sc_q);
      out_by = to_pix(cy + 19'(sd_q[3]), sc_q);
    end
  end

  // Output register valid flag.
  always_comb begin
    ov_d = ov_q;
    if (pop_i && ov_q) begin
      ov_d = 1'b0;
    end
    if (out_load) begin
      ov_d = 1'b1;
    end
  end

  assign empty_o = !ov_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q    <= 1'b0;
      k_q     <= '0;
      i_q     <= '0;
      cls_q   <= 1'b0;
      lside_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
      k_q     <= k_d;
      i_q     <= i_d;
      cls_q   <= cls_d;
      lside_q <= lside_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    mx_q    <= mx_d;
    n_q     <= n_d;
    p1_q    <= p1_d;
    e_q     <= e_d;
    sum_q   <= sum_d;
    wsum_q  <= wsum_d;
    rem_q   <= rem_d;
    den_q   <= den_d;
    quot_q  <= quot_d;
    neg_q   <= neg_d;
    side_q  <= side_d;
    gx_q    <= gx_d;
    gy_q    <= gy_d;
    sc_q    <= sc_d;
    score_q <= score_d;
    if (bin_we) begin
      bin_q[q_item_i.bin[BW-1:0]] <= q_item_i.logit;
    end
    if (sd_we) begin
      sd_q[side_q] <= sd_wdata;
    end
    if (out_load) begin
      kind_o     <= out_kind;
      left_x_o   <= out_lx;
      top_y_o    <= out_ty;
      right_x_o  <= out_rx;
      bottom_y_o <= out_by;
      score_o    <= out_score;
    end
  end

endmodule

// ----- rtl/dfl_box_decode.sv -----
`timescale 1ns / 1ps
// Channel   | Handshake            | Beat fields
// ----------+----------------------+------------------------------------------------
// input     | push / full          | command_i, logit_i, grid_x_i, grid_y_i,
//           |                      | stride_code_i
// result    | empty / pop          | kind_o, left_x_o, top_y_o, right_x_o,
//           |                      | bottom_y_o, score_o
//
// A box bin beat that does not close a side is only stored in the back end.
// The beat that closes a side starts a max search over the bins, exp accumulation
// through states N, E1, E2 and ACC for each bin, a setup step, a restoring divider
// of max(clog2(BINS)+8, 17) quotient bits and a store. A class beat takes two exp
// table multiplies, divider setup, 17 divide steps, the score update and the load.
// A two-entry queue between front and back raises full when it fills; a held
// result stalls the back end. Reset clears counters, pointers and control flags.
module dfl_box_decode #(
  parameter int BINS = dbd_pkg::BINS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic               command_i,
  input  logic signed [15:0] logit_i,
  input  logic [7:0]         grid_x_i,
  input  logic [7:0]         grid_y_i,
  input  logic [1:0]         stride_code_i,
  output logic               empty,
  input  logic               pop,
  output logic               kind_o,
  output logic signed [15:0] left_x_o,
  output logic signed [15:0] top_y_o,
  output logic signed [15:0] right_x_o,
  output logic signed [15:0] bottom_y_o,
  output logic [15:0]        score_o
);

  logic               q_push;
  logic               q_full;
  logic               q_valid;
  logic               q_pop;
  dbd_pkg::dbd_item_t q_in;
  dbd_pkg::dbd_item_t q_out;

  assign full = q_full;

  // Classify and tag input beats.
  dbd_front #(.BINS(BINS)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .q_full_i      (q_full),
    .command_i     (command_i),
    .logit_i       (logit_i),
    .grid_x_i      (grid_x_i),
    .grid_y_i      (grid_y_i),
    .stride_code_i (stride_code_i),
    .q_push_o      (q_push),
    .q_item_o      (q_in)
  );

  // Decoupling queue.
  dbd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_out)
  );

  // Softmax expectation, sigmoid and box assembly.
  dbd_back #(.BINS(BINS)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_item_i   (q_out),
    .q_pop_o    (q_pop),
    .empty_o    (empty),
    .pop_i      (pop),
    .kind_o     (kind_o),
    .left_x_o   (left_x_o),
    .top_y_o    (top_y_o),
    .right_x_o  (right_x_o),
    .bottom_y_o (bottom_y_o),
    .score_o    (score_o)
  );

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

  localparam int NBINS      = dbd_pkg::BINS_DEF;
  localparam int ITEM_GOAL  = 900;
  localparam int DRAIN_WAIT = 300;
  localparam int CYCLE_CAP  = 600000;

  typedef struct {
    logic               kind;
    logic signed [15:0] left_x;
    logic signed [15:0] top_y;
    logic signed [15:0] right_x;
    logic signed [15:0] bottom_y;
    logic [15:0]        score;
  } box_result_t;

  // Predicts decoded boxes and class scores and holds the results still owed.
  class dfl_scoreboard;
    box_result_t        owed_results[$];
    int                 fail_count;
    logic signed [15:0] side_logits[NBINS];
    int                 bin_cnt;
    int                 side_cnt;
    longint             side_dist[4];
    int                 exp_int_q[12];
    int                 exp_hi_q[16];
    int                 exp_lo_q[16];

    function new();
      exp_int_q = '{65536, 24109, 8869, 3263, 1200, 442, 162, 60, 22, 8, 3, 1};
      exp_hi_q  = '{65536, 61565, 57835, 54331, 51039, 47947, 45042, 42313,
                    39750, 37341, 35079, 32954, 30957, 29081, 27319, 25664};
      exp_lo_q  = '{65536, 65280, 65026, 64772, 64520, 64268, 64018, 63768,
                    63520, 63272, 63025, 62780, 62535, 62291, 62048, 61806};
      fail_count = 0;
      bin_cnt = 0;
      side_cnt = 0;
    endfunction

    // exp(-n) for n in Q8.8, as a product of three rounded Q0.16 factors.
    function longint exp_neg(longint n);
      longint r;
      if ((n >> 8) > 11) return 0;
      r = exp_int_q[n >> 8];
      r = (r * exp_hi_q[(n >> 4) & 15] + 32768) >> 16;
      r = (r * exp_lo_q[n & 15] + 32768) >> 16;
      return r;
    endfunction

    // Softmax expectation of the collected side, in Q4.8.
    function longint side_mean();
      longint mx, e, sum, wsum, d;
      mx = side_logits[0];
      sum = 0;
      wsum = 0;
      for (int k = 1; k < NBINS; k++)
        if (side_logits[k] > mx) mx = side_logits[k];
      for (int k = 0; k < NBINS; k++) begin
        e = exp_neg(mx - longint'(side_logits[k]));
        sum += e;
        wsum += e * k;
      end
      d = (wsum * 256 + sum / 2) / sum;
      return (d > 4095) ? 4095 : d;
    endfunction

    // Q8.8 grid units times stride, rounded half up to saturated Q12.4.
    function logic [15:0] to_pixels(longint v, longint stride);
      longint p, q;
      p = v * stride + 8;
      q = (p >= 0) ? p / 16 : -((-p + 15) / 16);
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return q[15:0];
    endfunction

    function logic [15:0] sigmoid(longint x);
      longint e, s;
      if (x >= 0) begin
        e = exp_neg(x);
        s = ((longint'(1) << 32) + (65536 + e) / 2) / (65536 + e);
      end else begin
        e = exp_neg(-x);
        s = (e * 65536 + (65536 + e) / 2) / (65536 + e);
      end
      return (s > 65535) ? 16'hFFFF : s[15:0];
    endfunction

    // Called for each accepted input beat.
    function void note_beat(logic cmd, logic signed [15:0] logit, logic [7:0] gx,
                            logic [7:0] gy, logic [1:0] sc);
      box_result_t r;
      longint cx, cy, stride;
      r = '{kind: dbd_pkg::CMD_BOX, left_x: 0, top_y: 0, right_x: 0, bottom_y: 0,
            score: 0};
      if (cmd == dbd_pkg::CMD_CLS) begin
        r.kind = dbd_pkg::CMD_CLS;
        r.score = sigmoid(logit);
        owed_results.insert(owed_results.size(), r);
        return;
      end
      side_logits[bin_cnt] = logit;
      bin_cnt++;
      if (bin_cnt < NBINS) return;
      bin_cnt = 0;
      side_dist[side_cnt] = side_mean();
      side_cnt++;
      if (side_cnt < 4) return;
      side_cnt = 0;
      // Stride code three decodes as stride 32.
      stride = (sc == 2'd0) ? 8 : ((sc == 2'd1) ? 16 : 32);
      cx = longint'(gx) * 256 + 128;
      cy = longint'(gy) * 256 + 128;
      r.left_x   = to_pixels(cx - side_dist[0], stride);
      r.top_y    = to_pixels(cy - side_dist[1], stride);
      r.right_x  = to_pixels(cx + side_dist[2], stride);
      r.bottom_y = to_pixels(cy + side_dist[3], stride);
      owed_results.insert(owed_results.size(), r);
    endfunction

    // Called for each accepted result beat.
    function void check_beat(box_result_t act);
      box_result_t w;
      if (owed_results.size() == 0) begin
        $error("result beat with no prediction waiting");
        fail_count++;
        return;
      end
      w = owed_results.pop_front();
      if (act.kind !== w.kind) begin
        $error("kind: expected %0d, got %0d", w.kind, act.kind);
        fail_count++;
      end
      if (act.left_x !== w.left_x) begin
        $error("left_x: expected %0d, got %0d", w.left_x, act.left_x);
        fail_count++;
      end
      if (act.top_y !== w.top_y) begin
        $error("top_y: expected %0d, got %0d", w.top_y, act.top_y);
        fail_count++;
      end
      if (act.right_x !== w.right_x) begin
        $error("right_x: expected %0d, got %0d", w.right_x, act.right_x);
        fail_count++;
      end
      if (act.bottom_y !== w.bottom_y) begin
        $error("bottom_y: expected %0d, got %0d", w.bottom_y, act.bottom_y);
        fail_count++;
      end
      if (act.score !== w.score) begin
        $error("score: expected %0d, got %0d", w.score, act.score);
        fail_count++;
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               push = 1'b0;
  logic               full;
  logic               command_i = dbd_pkg::CMD_BOX;
  logic signed [15:0] logit_i = '0;
  logic [7:0]         grid_x_i = '0;
  logic [7:0]         grid_y_i = '0;
  logic [1:0]         stride_code_i = '0;
  logic               empty;
  logic               pop = 1'b0;
  logic               kind_o;
  logic signed [15:0] left_x_o, top_y_o, right_x_o, bottom_y_o;
  logic [15:0]        score_o;

  dfl_box_decode i_dut (
    .clk_i, .rst_ni, .push, .full, .command_i, .logit_i, .grid_x_i, .grid_y_i,
    .stride_code_i, .empty, .pop, .kind_o, .left_x_o, .top_y_o, .right_x_o,
    .bottom_y_o, .score_o
  );

  dfl_scoreboard board = new();
  int            beats_sent = 0;
  bit            no_idle = 1'b0;
  longint        cycle_cnt = 0;

  always #5 clk_i = ~clk_i;

  // Run limit.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_CAP) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result side: check accepted beats and stall pop at random.
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty)
      board.check_beat('{kind: kind_o, left_x: left_x_o, top_y: top_y_o,
                         right_x: right_x_o, bottom_y: bottom_y_o, score: score_o});
    pop <= no_idle || ($urandom_range(99) >= 8);
  end

  // Drives one input beat, sometimes after idling with push low first.
  task automatic send_beat(logic cmd, logic signed [15:0] logit, logic [7:0] gx,
                           logic [7:0] gy, logic [1:0] sc);
    if (!no_idle && $urandom_range(99) < 8) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push          <= 1'b1;
    command_i     <= cmd;
    logit_i       <= logit;
    grid_x_i      <= gx;
    grid_y_i      <= gy;
    stride_code_i <= sc;
    do @(posedge clk_i); while (full);
    board.note_beat(cmd, logit, gx, gy, sc);
    beats_sent++;
  endtask

  // Logit drawn either near a center value or over the full range.
  function automatic logic signed [15:0] pick_logit(int spread, int center);
    int v;
    if (spread == 0) return 16'($urandom);
    v = center + $signed($urandom_range(2 * spread)) - spread;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  // One whole box of 64 bin beats; class beats may be mixed in mid-box.
  task automatic send_box(int spread, int cls_pct, logic [7:0] gx, logic [7:0] gy,
                          logic [1:0] sc);
    int center;
    center = $signed($urandom_range(8000)) - 4000;
    for (int i = 0; i < 4 * NBINS; i++) begin
      if ($urandom_range(99) < cls_pct)
        send_beat(dbd_pkg::CMD_CLS, 16'($urandom), 8'($urandom), 8'($urandom),
                  2'($urandom));
      // Anchor fields of earlier beats are random; only the last beat's count.
      if (i == 4 * NBINS - 1)
        send_beat(dbd_pkg::CMD_BOX, pick_logit(spread, center), gx, gy, sc);
      else
        send_beat(dbd_pkg::CMD_BOX, pick_logit(spread, center), 8'($urandom),
                  8'($urandom), 2'($urandom));
    end
  endtask

  initial begin
    int          wait_cnt;
    logic [15:0] cls_vals[10];
    cls_vals = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001, 16'h0B00,
                 16'hF500, 16'h0C00, 16'hF400, 16'h0080};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: class logit extremes and exp table edges.
    foreach (cls_vals[i])
      send_beat(dbd_pkg::CMD_CLS, cls_vals[i], 8'd0, 8'd0, 2'd0);
    // Flat distribution, each stride code, grid corners and saturation.
    for (int c = 0; c < 4; c++)
      send_box(1, 0, (c[0]) ? 8'd255 : 8'd0, (c[1]) ? 8'd255 : 8'd0, c[1:0]);
    // Widest logit spread, once with class beats inside the box and once without.
    send_box(0, 20, 8'd255, 8'd0, 2'd2);
    send_box(32767, 0, 8'd0, 8'd255, 2'd3);

    // Random boxes with mixed class beats; one long stretch with no idling.
    while (beats_sent < ITEM_GOAL) begin
      no_idle = (beats_sent > 350 && beats_sent < 600);
      case ($urandom_range(3))
        0: send_box(0, 5, 8'($urandom), 8'($urandom), 2'($urandom));
        1: send_box($urandom_range(300), 5, 8'($urandom), 8'($urandom), 2'($urandom));
        default: send_box($urandom_range(3000), 5, 8'($urandom), 8'($urandom),
                          2'($urandom));
      endcase
    end
    no_idle = 1'b0;
    push <= 1'b0;

    wait_cnt = 0;
    while (board.owed_results.size() != 0 && wait_cnt < 20000) begin
      @(posedge clk_i);
      wait_cnt++;
    end
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (board.owed_results.size() != 0) begin
      $error("%0d predicted results never arrived", board.owed_results.size());
      board.fail_count++;
    end
    if (board.fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/dbd_pkg.sv
rtl/dbd_front.sv
rtl/dbd_fifo.sv
rtl/dbd_back.sv
rtl/dfl_box_decode.sv
tb/testbench.sv
